/* rtl/ffba_pkg.sv */
// ----------------------------------------------------------------------------
// ffba_pkg: shared types and constants of the first-fit block allocator
// Word geometry of the map cells, scan link and mark command words, codes.
// ----------------------------------------------------------------------------
package ffba_pkg;

	localparam int WORD_W   = 32;
	localparam int IDX_W    = 5;
	localparam int LEN_W    = 7;
	localparam int POS_W    = 16;
	localparam int BLOCK_W  = 10;
	localparam int STATUS_W = 2;
	localparam int LEN_MAX  = (1 << LEN_W) - 1;

	localparam logic MODE_ACQUIRE = 1'b0;
	localparam logic MODE_FREE    = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_NO_SPACE = 2'd1,
		STAT_RANGE    = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic             tok;
		logic             found;
		logic [LEN_W-1:0] carry;
		logic [POS_W-1:0] start;
	} link_t;

	typedef struct packed {
		logic             en;
		logic             set;
		logic [POS_W-1:0] start;
		logic [LEN_W-1:0] len;
	} mark_t;

endpackage

/* rtl/ffba_cell.sv */
// ----------------------------------------------------------------------------
// ffba_cell: one word of the used map
// Holds 32 map bits, evaluates the passing scan word against them and hands
// the running free count and first hit on to the next cell. Applies the
// broadcast mark command to its own bits.
// ----------------------------------------------------------------------------
module ffba_cell #(
	parameter int INDEX = 0,
	parameter int LW    = 11
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ffba_pkg::link_t          link_in,
	output ffba_pkg::link_t          link_out,
	input  ffba_pkg::mark_t          mark,
	input  logic [LW-1:0]            scan_limit,
	input  logic [ffba_pkg::LEN_W-1:0] run_len
);

	localparam int WW   = ffba_pkg::WORD_W;
	localparam int IW   = ffba_pkg::IDX_W;
	localparam int LNW  = ffba_pkg::LEN_W;
	localparam int PW   = ffba_pkg::POS_W;
	localparam int BASE = INDEX * WW;
	localparam int SW   = $clog2(IW + 1);

	logic [WW-1:0]     word_q;
	ffba_pkg::link_t   link_q;

	logic [WW-1:0]     smear [IW+1];
	logic [IW:0]       m;
	logic [IW:0]       kb;
	logic [IW:0]       d;
	logic [WW-1:0]     sel;
	logic [WW-1:0]     sm;
	logic [WW-1:0]     pfree;
	logic [WW-1:0]     lim;
	logic [WW-1:0]     hit;
	logic [IW:0]       rem;
	logic [LW:0]       diff;
	logic [IW-1:0]     lo_idx;
	logic [IW-1:0]     hi_used;
	logic [IW:0]       lead;
	logic [LNW:0]      csum;
	logic [LNW-1:0]    carry_d;
	logic [PW:0]       st;
	logic              any_hit;
	logic [WW-1:0]     mmask;
	logic signed [PW+1:0] lo;
	logic signed [PW+1:0] hi;
	logic [IW:0]       lo_c;
	logic [IW:0]       hi_c;

	// used bits smeared upward over the request length
	always_comb begin
		smear[0] = word_q;
		for (int k = 1; k <= IW; k++) begin
			smear[k] = smear[k-1] | (smear[k-1] << (1 << (k-1)));
		end
		m = (run_len >= LNW'(WW)) ? (IW+1)'(WW) : (IW+1)'(run_len);
		kb = '0;
		for (int b = 0; b <= IW; b++) begin
			if (m[b]) begin
				kb = (IW+1)'(b);
			end
		end
		sel = smear[kb[SW-1:0]];
		if (kb == (IW+1)'(IW)) begin
			sel = smear[IW];
		end
		d = m - ((IW+1)'(1) << kb);
		sm = sel | (sel << d);
		pfree = ~smear[IW];
	end

	always_comb begin
		if ((LW+1)'(scan_limit) <= (LW+1)'(BASE)) begin
			diff = '0;
			rem = '0;
		end else begin
			diff = (LW+1)'(scan_limit) - (LW+1)'(BASE);
			rem = (diff >= (LW+1)'(WW)) ? (IW+1)'(WW) : diff[IW:0];
		end
		for (int i = 0; i < WW; i++) begin
			lim[i] = (IW+1)'(i) < rem;
			hit[i] = ~sm[i] & lim[i] &
				((8'(i + 1) >= 8'(run_len)) |
				 (pfree[i] & (8'(i + 1) + 8'(link_in.carry) >= 8'(run_len))));
		end
		any_hit = |hit;
		lo_idx = '0;
		for (int i = WW - 1; i >= 0; i--) begin
			if (hit[i]) begin
				lo_idx = IW'(i);
			end
		end
		hi_used = '0;
		for (int i = 0; i < WW; i++) begin
			if (word_q[i]) begin
				hi_used = IW'(i);
			end
		end
		lead = (IW+1)'(WW - 1) - (IW+1)'(hi_used);
		csum = (LNW+1)'(link_in.carry) + (LNW+1)'(WW);
		if (pfree[WW-1]) begin
			carry_d = (csum > (LNW+1)'(ffba_pkg::LEN_MAX)) ? LNW'(ffba_pkg::LEN_MAX) :
				csum[LNW-1:0];
		end else begin
			carry_d = LNW'(lead);
		end
		st = (PW+1)'(BASE) + (PW+1)'(lo_idx) + (PW+1)'(1) - (PW+1)'(run_len);
	end

	// mark window clipped to this word
	always_comb begin
		lo = $signed({2'b00, mark.start}) - (PW+2)'(BASE);
		hi = lo + $signed((PW+2)'(mark.len));
		if (lo < 0) begin
			lo_c = '0;
		end else if (lo > (PW+2)'(WW)) begin
			lo_c = (IW+1)'(WW);
		end else begin
			lo_c = lo[IW:0];
		end
		if (hi < 0) begin
			hi_c = '0;
		end else if (hi > (PW+2)'(WW)) begin
			hi_c = (IW+1)'(WW);
		end else begin
			hi_c = hi[IW:0];
		end
		for (int i = 0; i < WW; i++) begin
			mmask[i] = ((IW+1)'(i) >= lo_c) && ((IW+1)'(i) < hi_c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
			link_q <= '0;
		end else begin
			if (mark.en) begin
				word_q <= mark.set ? (word_q | mmask) : (word_q & ~mmask);
			end
			link_q.tok   <= link_in.tok;
			link_q.found <= link_in.found | any_hit;
			link_q.carry <= carry_d;
			link_q.start <= link_in.found ? link_in.start : PW'(st);
		end
	end

	assign link_out = link_q;

endmodule

/* rtl/first_fit_block_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_block_allocator: first-fit contiguous block allocator
// The used map lives in a chain of 32-bit cells, CAPACITY/32 rounded up. An
// acquire sends one scan word down the chain, one cell per cycle, and no new
// request is taken until its result has moved to the output register; the
// lowest fitting run below the used length wins, otherwise the run grows the
// used length if that stays within CAPACITY. A free, or an acquire with a bad
// length, skips the scan. The map and used length are clear straight after
// reset. A finished result sits in an output register, so a new request is
// taken while it waits.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
	parameter int CAPACITY = 1024,
	parameter int MAX_RUN  = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          mode,
	input  logic [ffba_pkg::LEN_W-1:0]    run_length,
	input  logic [ffba_pkg::BLOCK_W-1:0]  first_block,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ffba_pkg::BLOCK_W-1:0]  start_block,
	output logic [ffba_pkg::STATUS_W-1:0] status
);

	localparam int NC  = (CAPACITY + ffba_pkg::WORD_W - 1) / ffba_pkg::WORD_W;
	localparam int LW  = $clog2(CAPACITY + 1);
	localparam int GW  = ((LW > ffba_pkg::LEN_W) ? LW : ffba_pkg::LEN_W) + 1;
	localparam int PW  = ffba_pkg::POS_W;
	localparam int BW  = ffba_pkg::BLOCK_W;

	ffba_pkg::state_t  state_q;
	ffba_pkg::state_t  state_d;
	ffba_pkg::link_t   links [NC+1];
	ffba_pkg::link_t   last;
	ffba_pkg::mark_t   mark_q;
	ffba_pkg::status_t res_status_q;
	ffba_pkg::status_t status_q;

	logic                       kick_q;
	logic [LW-1:0]              used_len_q;
	logic [ffba_pkg::LEN_W-1:0] len_q;
	logic [BW-1:0]              res_start_q;
	logic [BW-1:0]              start_q;
	logic                       out_valid_q;
	logic                       accept;
	logic                       acq_bad;
	logic                       free_bad;
	logic                       fit_growth;
	logic                       scan_end;
	logic                       out_load;
	logic [NC-1:0]              tok_vec;

	assign last       = links[NC];
	assign accept     = in_valid && in_ready;
	assign scan_end   = (state_q == ffba_pkg::S_SCAN) && last.tok;
	assign acq_bad    = (run_length == '0) || (32'(run_length) > 32'(MAX_RUN));
	assign free_bad   = (32'(run_length) > 32'(MAX_RUN)) ||
		(32'(first_block) + 32'(run_length) > 32'(CAPACITY));
	assign fit_growth = (GW'(used_len_q) + GW'(len_q)) <= GW'(CAPACITY);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ffba_pkg::S_IDLE: begin
				if (in_valid) begin
					if (mode == ffba_pkg::MODE_FREE || acq_bad) begin
						state_d = ffba_pkg::S_DONE;
					end else begin
						state_d = ffba_pkg::S_SCAN;
					end
				end
			end
			ffba_pkg::S_SCAN: begin
				if (last.tok) begin
					state_d = ffba_pkg::S_DONE;
				end
			end
			ffba_pkg::S_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = ffba_pkg::S_IDLE;
				end
			end
			default: state_d = ffba_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ffba_pkg::S_IDLE);
		out_load = (state_q == ffba_pkg::S_DONE) && (!out_valid_q || out_ready);
	end

	assign links[0] = '{tok: kick_q, found: 1'b0, carry: '0, start: '0};

	genvar g;
	generate
		for (g = 0; g < NC; g++) begin : g_cell
			ffba_cell #(
				.INDEX (g),
				.LW    (LW)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.link_in    (links[g]),
				.link_out   (links[g+1]),
				.mark       (mark_q),
				.scan_limit (used_len_q),
				.run_len    (len_q)
			);
			assign tok_vec[g] = links[g+1].tok;
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ffba_pkg::S_IDLE;
			kick_q      <= 1'b0;
			used_len_q  <= '0;
			mark_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			kick_q    <= accept && (mode == ffba_pkg::MODE_ACQUIRE) && !acq_bad;
			if (accept && mode == ffba_pkg::MODE_FREE && !free_bad) begin
				mark_q <= '{en: 1'b1, set: 1'b0, start: PW'(first_block), len: run_length};
			end else if (scan_end && last.found) begin
				mark_q <= '{en: 1'b1, set: 1'b1, start: last.start, len: len_q};
			end else if (scan_end && fit_growth) begin
				mark_q <= '{en: 1'b1, set: 1'b1, start: PW'(used_len_q), len: len_q};
				used_len_q <= LW'(GW'(used_len_q) + GW'(len_q));
			end else begin
				mark_q.en <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			len_q       <= run_length;
			res_start_q <= '0;
			if (mode == ffba_pkg::MODE_FREE) begin
				res_status_q <= free_bad ? ffba_pkg::STAT_RANGE : ffba_pkg::STAT_OK;
			end else begin
				res_status_q <= acq_bad ? ffba_pkg::STAT_NO_SPACE : ffba_pkg::STAT_OK;
			end
		end
		if (scan_end) begin
			if (last.found) begin
				res_start_q  <= BW'(last.start);
				res_status_q <= ffba_pkg::STAT_OK;
			end else if (fit_growth) begin
				res_start_q  <= BW'(used_len_q);
				res_status_q <= ffba_pkg::STAT_OK;
			end else begin
				res_start_q  <= '0;
				res_status_q <= ffba_pkg::STAT_NO_SPACE;
			end
		end
		if (out_load) begin
			start_q  <= res_start_q;
			status_q <= res_status_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign start_block = start_q;
	assign status      = ffba_pkg::STATUS_W'(status_q);

	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		32'(used_len_q) <= 32'(CAPACITY))
		else $error("used length beyond capacity");

	a_len_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> used_len_q >= $past(used_len_q))
		else $error("used length shrank");

	a_one_tok: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vec))
		else $error("more than one scan word in the chain");

	a_tok_scan: assert property (@(posedge clk) disable iff (!arst_n)
		last.tok |-> state_q == ffba_pkg::S_SCAN)
		else $error("scan word left the chain outside a scan");

	a_mark_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mark_q.en |-> state_q == ffba_pkg::S_DONE)
		else $error("map written outside the result phase");

endmodule

/* sim/first_fit_block_allocator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator_tb: self-checking bench of the first-fit allocator
// Drives acquire and free words through the valid/ready input channel. A shadow
// of the used map and used length predicts each reply word. The bench starts
// with a directed run of edge cases, then random traffic in four phases of
// sender idling and receiver stalling, draining all replies between phases.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_tb;

	localparam int CAPACITY    = 1024;
	localparam int MAX_RUN     = 64;
	localparam int PHASE_WORDS = 325;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct {
		logic [ffba_pkg::BLOCK_W-1:0] start;
		ffba_pkg::status_t            stat;
	} reply_t;

	class block_map_shadow;
		bit     used_map [CAPACITY];
		int     used_len;
		reply_t due_replies [$];
		int     errors;

		function new();
			foreach (used_map[i]) used_map[i] = 1'b0;
			used_len = 0;
			errors   = 0;
		endfunction

		function reply_t allocate_or_free(logic m, logic [ffba_pkg::LEN_W-1:0] len,
				logic [ffba_pkg::BLOCK_W-1:0] first);
			reply_t r;
			int     run;
			int     base;
			bit     hit;
			r.start = '0;
			r.stat  = ffba_pkg::STAT_OK;
			if (m == ffba_pkg::MODE_ACQUIRE) begin
				if (len == 0 || int'(len) > MAX_RUN) begin
					r.stat = ffba_pkg::STAT_NO_SPACE;
				end else begin
					hit  = 1'b0;
					run  = 0;
					base = 0;
					for (int i = 0; i < used_len && !hit; i++) begin
						if (!used_map[i]) begin
							run++;
							if (run == int'(len)) begin
								hit  = 1'b1;
								base = i + 1 - int'(len);
							end
						end else begin
							run = 0;
						end
					end
					if (!hit && used_len + int'(len) <= CAPACITY) begin
						hit      = 1'b1;
						base     = used_len;
						used_len = used_len + int'(len);
					end
					if (hit) begin
						for (int i = 0; i < int'(len); i++) used_map[base + i] = 1'b1;
						r.start = base[ffba_pkg::BLOCK_W-1:0];
					end else begin
						r.stat = ffba_pkg::STAT_NO_SPACE;
					end
				end
			end else begin
				if (int'(len) > MAX_RUN || int'(first) + int'(len) > CAPACITY) begin
					r.stat = ffba_pkg::STAT_RANGE;
				end else begin
					for (int i = 0; i < int'(len); i++) used_map[int'(first) + i] = 1'b0;
				end
			end
			return r;
		endfunction

		function reply_t note_request(logic m, logic [ffba_pkg::LEN_W-1:0] len,
				logic [ffba_pkg::BLOCK_W-1:0] first);
			reply_t r;
			r = allocate_or_free(m, len, first);
			due_replies.push_back(r);
			return r;
		endfunction

		function void check_reply(logic [ffba_pkg::BLOCK_W-1:0] start,
				logic [ffba_pkg::STATUS_W-1:0] stat);
			reply_t exp;
			if (due_replies.size() == 0) begin
				$error("unexpected result word: start_block %0d status %0d", start, stat);
				errors++;
			end else begin
				exp = due_replies.pop_front();
				if (start !== exp.start) begin
					$error("start_block: expected %0d, actual %0d", exp.start, start);
					errors++;
				end
				if (stat !== exp.stat) begin
					$error("status: expected %0d, actual %0d", exp.stat, stat);
					errors++;
				end
			end
		endfunction
	endclass

	logic                          clk         = 1'b0;
	logic                          arst_n      = 1'b0;
	logic                          in_valid    = 1'b0;
	logic                          in_ready;
	logic                          mode        = ffba_pkg::MODE_ACQUIRE;
	logic [ffba_pkg::LEN_W-1:0]    run_length  = '0;
	logic [ffba_pkg::BLOCK_W-1:0]  first_block = '0;
	logic                          out_valid;
	logic                          out_ready   = 1'b0;
	logic [ffba_pkg::BLOCK_W-1:0]  start_block;
	logic [ffba_pkg::STATUS_W-1:0] status;

	block_map_shadow               shadow = new();
	int                            send_idle_pct;
	int                            recv_stall_pct;
	int                            cycle_count;
	logic [ffba_pkg::BLOCK_W-1:0]  live_first [$];
	logic [ffba_pkg::LEN_W-1:0]    live_len [$];

	first_fit_block_allocator #(
		.CAPACITY(CAPACITY),
		.MAX_RUN (MAX_RUN)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.run_length (run_length),
		.first_block(first_block),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.start_block(start_block),
		.status     (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) shadow.check_reply(start_block, status);
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic issue_word(logic m, logic [ffba_pkg::LEN_W-1:0] len,
			logic [ffba_pkg::BLOCK_W-1:0] first);
		reply_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		mode        <= m;
		run_length  <= len;
		first_block <= first;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		r = shadow.note_request(m, len, first);
		if (m == ffba_pkg::MODE_ACQUIRE && r.stat == ffba_pkg::STAT_OK) begin
			live_first.push_back(r.start);
			live_len.push_back(len);
		end
	endtask

	task automatic random_word();
		int                           pick;
		int                           idx;
		int                           part;
		logic [ffba_pkg::LEN_W-1:0]   len;
		logic [ffba_pkg::BLOCK_W-1:0] first;
		pick  = $urandom_range(99);
		first = ffba_pkg::BLOCK_W'($urandom_range(CAPACITY - 1));
		if (pick < 45) begin
			if ($urandom_range(99) < 4)
				len = $urandom_range(1) ? 7'd0 : 7'($urandom_range(127, MAX_RUN + 1));
			else if ($urandom_range(1))
				len = ffba_pkg::LEN_W'($urandom_range(8, 1));
			else
				len = ffba_pkg::LEN_W'($urandom_range(MAX_RUN, 1));
			issue_word(ffba_pkg::MODE_ACQUIRE, len, first);
		end else if (pick < 82 && live_first.size() != 0) begin
			idx   = $urandom_range(live_first.size() - 1);
			first = live_first[idx];
			len   = live_len[idx];
			live_first.delete(idx);
			live_len.delete(idx);
			// free a prefix now and keep the tail for later
			if (len > 1 && $urandom_range(99) < 20) begin
				part = $urandom_range(int'(len) - 1, 1);
				live_first.push_back(first + ffba_pkg::BLOCK_W'(part));
				live_len.push_back(len - ffba_pkg::LEN_W'(part));
				len = ffba_pkg::LEN_W'(part);
			end
			issue_word(ffba_pkg::MODE_FREE, len, first);
		end else begin
			len = ffba_pkg::LEN_W'($urandom_range(127));
			issue_word(ffba_pkg::MODE_FREE, len, first);
		end
	endtask

	initial begin
		int send_pct [4];
		int recv_pct [4];
		send_pct = '{0, 87, 0, 27};
		recv_pct = '{0, 0, 87, 27};
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		cycle_count    = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue_word(ffba_pkg::MODE_ACQUIRE, 7'd0, 10'd0);
		issue_word(ffba_pkg::MODE_ACQUIRE, 7'd65, 10'd0);
		issue_word(ffba_pkg::MODE_ACQUIRE, 7'd127, 10'd1023);
		issue_word(ffba_pkg::MODE_FREE, 7'd24, 10'd1000);
		issue_word(ffba_pkg::MODE_ACQUIRE, 7'd1, 10'd1023);
		issue_word(ffba_pkg::MODE_ACQUIRE, 7'd64, 10'd0);
		issue_word(ffba_pkg::MODE_ACQUIRE, 7'd5, 10'd0);
		issue_word(ffba_pkg::MODE_FREE, 7'd1, 10'd0);
		issue_word(ffba_pkg::MODE_ACQUIRE, 7'd1, 10'd0);
		issue_word(ffba_pkg::MODE_FREE, 7'd64, 10'd1);
		issue_word(ffba_pkg::MODE_ACQUIRE, 7'd3, 10'd0);
		issue_word(ffba_pkg::MODE_ACQUIRE, 7'd61, 10'd0);
		issue_word(ffba_pkg::MODE_ACQUIRE, 7'd62, 10'd0);
		issue_word(ffba_pkg::MODE_FREE, 7'd2, 10'd1023);
		issue_word(ffba_pkg::MODE_FREE, 7'd65, 10'd0);
		issue_word(ffba_pkg::MODE_FREE, 7'd127, 10'd512);
		issue_word(ffba_pkg::MODE_FREE, 7'd0, 10'd1023);
		issue_word(ffba_pkg::MODE_FREE, 7'd64, 10'd960);
		issue_word(ffba_pkg::MODE_FREE, 7'd1, 10'd1023);
		live_first.delete();
		live_len.delete();

		for (int p = 0; p < 4; p++) begin
			// hold the sender until every reply word is back
			in_valid <= 1'b0;
			while (shadow.due_replies.size() != 0) @(posedge clk);
			send_idle_pct  = send_pct[p];
			recv_stall_pct = recv_pct[p];
			for (int n = 0; n < PHASE_WORDS; n++) random_word();
		end

		in_valid <= 1'b0;
		while (shadow.due_replies.size() != 0) @(posedge clk);
		repeat (64) @(posedge clk);
		if (shadow.errors == 0 && shadow.due_replies.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
